@@ hw/rtl/tod_pkg.sv @@
package tod_pkg;

  // configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // default sample width
  localparam int unsigned SampleBitsDef = 16;

  // register reset values
  localparam logic [14:0] TiltThresholdRst = 15'd1556;
  localparam logic [14:0] AxisMarginRst    = 15'd123;
  localparam logic [14:0] FlatThresholdRst = 15'd3359;
  localparam logic [14:0] GyroNoiseRst     = 15'd64;
  localparam logic [23:0] FlipYawRst       = 24'd1120000;
  localparam logic [3:0]  StableSamplesRst = 4'd3;
  localparam logic [15:0] MinGapRst        = 16'd850;
  localparam logic [1:0]  RotOffsetRst     = 2'd1;

  // yaw decay factor, applied as (yaw * 963) / 1024
  localparam int unsigned DecayMul   = 963;
  localparam int unsigned DecayShift = 10;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TILT_THRESHOLD = 3'd0,
    CFG_AXIS_MARGIN    = 3'd1,
    CFG_FLAT_THRESHOLD = 3'd2,
    CFG_GYRO_NOISE     = 3'd3,
    CFG_FLIP_YAW       = 3'd4,
    CFG_STABLE_SAMPLES = 3'd5,
    CFG_MIN_GAP_MS     = 3'd6,
    CFG_ROT_OFFSET     = 3'd7
  } cfg_idx_e;

  // physical orientation codes
  typedef enum logic [2:0] {
    ORIENT_UNKNOWN        = 3'd0,
    ORIENT_PORTRAIT       = 3'd1,
    ORIENT_LANDSCAPE      = 3'd2,
    ORIENT_PORTRAIT_FLIP  = 3'd3,
    ORIENT_LANDSCAPE_FLIP = 3'd4
  } orient_e;

  typedef struct packed {
    logic [14:0] tilt_threshold;
    logic [14:0] axis_margin;
    logic [14:0] flat_threshold;
    logic [14:0] gyro_noise;
    logic [23:0] flip_yaw_threshold;
    logic [3:0]  stable_samples;
    logic [15:0] min_rotation_gap_ms;
    logic [1:0]  rotation_offset;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         committed_rotation;
    logic [1:0]         candidate_rotation;
    logic [3:0]         stable_count;
    orient_e            last_orientation;
    logic signed [31:0] yaw_accumulator;
    logic [15:0]        ms_since_rotation;
  } state_t;

  typedef struct packed {
    logic [1:0] display_rotation;
    orient_e    orientation;
    logic       rotation_changed;
  } result_t;

  localparam cfg_t CfgRst = '{
    tilt_threshold:      TiltThresholdRst,
    axis_margin:         AxisMarginRst,
    flat_threshold:      FlatThresholdRst,
    gyro_noise:          GyroNoiseRst,
    flip_yaw_threshold:  FlipYawRst,
    stable_samples:      StableSamplesRst,
    min_rotation_gap_ms: MinGapRst,
    rotation_offset:     RotOffsetRst
  };

  localparam state_t StateRst = '{
    committed_rotation: 2'd1,
    candidate_rotation: 2'd1,
    stable_count:       4'd0,
    last_orientation:   ORIENT_UNKNOWN,
    yaw_accumulator:    32'sd0,
    ms_since_rotation:  16'd0
  };

  // display rotation from physical rotation
  function automatic logic [1:0] disp_of_phys(logic [1:0] phys, logic [1:0] offset);
    disp_of_phys = phys + offset;
  endfunction

endpackage

@@ hw/rtl/tod_step.sv @@
module tod_step #(
  parameter int unsigned SAMPLE_BITS = tod_pkg::SampleBitsDef
) (
  input  tod_pkg::cfg_t                 cfg_i,
  input  tod_pkg::state_t               state_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_x_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_y_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_z_i,
  input  logic signed [SAMPLE_BITS-1:0] gyro_z_i,
  input  logic [15:0]                   elapsed_ms_i,
  output tod_pkg::state_t               state_o,
  output tod_pkg::result_t              result_o
);

  localparam int unsigned CmpW  = ((SAMPLE_BITS > 24) ? SAMPLE_BITS : 24) + 2;
  localparam int unsigned ProdW = SAMPLE_BITS + 17;
  localparam int unsigned SumW  = ((ProdW > 33) ? ProdW : 33) + 1;
  localparam int unsigned DecW  = 32 + 11;

  logic [SAMPLE_BITS-1:0] abs_x, abs_y, abs_z, abs_g;
  logic [CmpW-1:0]        cx, cy, cz, cg, c_tilt, c_margin;
  logic [16:0]            ms_sum;
  logic [15:0]            ms_sat;
  logic signed [ProdW-1:0] yaw_prod;
  logic signed [SumW-1:0]  yaw_sum;
  logic signed [31:0]      yaw_int;
  logic signed [DecW-1:0]  dec_prod, dec_adj;
  logic signed [31:0]      yaw_dec;
  logic signed [31:0]      yaw_new;
  logic [32:0]             yaw_mag;
  logic                    is_flat, gyro_active, do_flip;
  tod_pkg::orient_e        tilt_orient;
  logic [1:0]              tilt_target;

  // magnitudes, most negative value maps to its unsigned magnitude
  assign abs_x = accel_x_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-accel_x_i) : accel_x_i;
  assign abs_y = accel_y_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-accel_y_i) : accel_y_i;
  assign abs_z = accel_z_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-accel_z_i) : accel_z_i;
  assign abs_g = gyro_z_i[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-gyro_z_i)  : gyro_z_i;

  assign cx       = CmpW'(abs_x);
  assign cy       = CmpW'(abs_y);
  assign cz       = CmpW'(abs_z);
  assign cg       = CmpW'(abs_g);
  assign c_tilt   = CmpW'(cfg_i.tilt_threshold);
  assign c_margin = CmpW'(cfg_i.axis_margin);

  // saturating elapsed time since last commit
  assign ms_sum = 17'(state_i.ms_since_rotation) + 17'(elapsed_ms_i);
  assign ms_sat = ms_sum[16] ? 16'hFFFF : ms_sum[15:0];

  // dominant tilt axis
  always_comb begin
    tilt_orient = tod_pkg::ORIENT_UNKNOWN;
    tilt_target = state_i.committed_rotation;
    priority if (cx < c_tilt && cy < c_tilt) begin
      tilt_orient = tod_pkg::ORIENT_UNKNOWN;
    end else if (cx >= cy + c_margin) begin
      if (!accel_x_i[SAMPLE_BITS-1]) begin
        tilt_orient = tod_pkg::ORIENT_PORTRAIT;
        tilt_target = tod_pkg::disp_of_phys(2'd0, cfg_i.rotation_offset);
      end else begin
        tilt_orient = tod_pkg::ORIENT_PORTRAIT_FLIP;
        tilt_target = tod_pkg::disp_of_phys(2'd2, cfg_i.rotation_offset);
      end
    end else if (cy >= cx + c_margin) begin
      if (!accel_y_i[SAMPLE_BITS-1]) begin
        tilt_orient = tod_pkg::ORIENT_LANDSCAPE;
        tilt_target = tod_pkg::disp_of_phys(2'd1, cfg_i.rotation_offset);
      end else begin
        tilt_orient = tod_pkg::ORIENT_LANDSCAPE_FLIP;
        tilt_target = tod_pkg::disp_of_phys(2'd3, cfg_i.rotation_offset);
      end
    end else begin
      // neither axis dominates by the margin
      tilt_orient = tod_pkg::ORIENT_UNKNOWN;
    end
  end

  // yaw integration, saturated to 32 bits
  assign yaw_prod = ProdW'(gyro_z_i) * ProdW'($signed({1'b0, elapsed_ms_i}));
  assign yaw_sum  = SumW'(state_i.yaw_accumulator) + SumW'(yaw_prod);
  always_comb begin
    if (yaw_sum > SumW'(32'sh7FFF_FFFF)) begin
      yaw_int = 32'sh7FFF_FFFF;
    end else if (yaw_sum < -SumW'(33'sh0_8000_0000)) begin
      yaw_int = 32'sh8000_0000;
    end else begin
      yaw_int = 32'(yaw_sum);
    end
  end

  // yaw decay, truncated toward zero
  assign dec_prod = DecW'(state_i.yaw_accumulator) * DecW'(tod_pkg::DecayMul);
  assign dec_adj  = dec_prod + (dec_prod[DecW-1] ? DecW'((1 << tod_pkg::DecayShift) - 1)
                                                 : DecW'(0));
  assign yaw_dec  = 32'(dec_adj >>> tod_pkg::DecayShift);

  assign is_flat     = cz >= CmpW'(cfg_i.flat_threshold);
  assign gyro_active = cg > CmpW'(cfg_i.gyro_noise);
  assign yaw_new     = gyro_active ? yaw_int : yaw_dec;
  assign yaw_mag     = yaw_new[31] ? 33'(-34'(yaw_new)) : 33'(yaw_new);
  assign do_flip     = (tilt_orient == tod_pkg::ORIENT_UNKNOWN) && is_flat &&
                       (yaw_mag >= 33'(cfg_i.flip_yaw_threshold));

  // candidate tracking and commit
  always_comb begin
    logic [1:0]       target;
    tod_pkg::orient_e orient;
    logic             changed;
    state_o = state_i;
    state_o.ms_since_rotation = ms_sat;
    target  = tilt_target;
    orient  = tilt_orient;
    changed = 1'b0;

    if (tilt_orient == tod_pkg::ORIENT_UNKNOWN) begin
      if (!is_flat) begin
        state_o.yaw_accumulator = 32'sd0;
      end else if (do_flip) begin
        target = state_i.committed_rotation + 2'd2;
        orient = tod_pkg::orient_e'(3'(2'(target - cfg_i.rotation_offset)) + 3'd1);
        state_o.yaw_accumulator    = 32'sd0;
        state_o.candidate_rotation = target;
        state_o.stable_count       = cfg_i.stable_samples;
      end else begin
        state_o.yaw_accumulator = yaw_new;
      end
    end

    state_o.last_orientation = orient;
    if (orient == tod_pkg::ORIENT_UNKNOWN) begin
      state_o.stable_count = 4'd0;
    end else begin
      state_o.yaw_accumulator = 32'sd0;
      priority if (target != state_o.candidate_rotation) begin
        state_o.candidate_rotation = target;
        state_o.stable_count       = 4'd1;
      end else if (state_o.stable_count < cfg_i.stable_samples) begin
        state_o.stable_count = state_o.stable_count + 4'd1;
      end else if (target != state_i.committed_rotation &&
                   ms_sat >= cfg_i.min_rotation_gap_ms) begin
        state_o.committed_rotation = target;
        state_o.ms_since_rotation  = 16'd0;
        changed = 1'b1;
      end else begin
        // already committed or gap not yet met
        changed = 1'b0;
      end
    end

    result_o.display_rotation = state_o.committed_rotation;
    result_o.orientation      = orient;
    result_o.rotation_changed = changed;
  end

endmodule

@@ hw/rtl/tilt_orientation_detector.sv @@
// channel  | direction | handshake               | payload
// in       | input     | in_valid_i / in_stall_o  | accel_x/y/z, gyro_z, elapsed_ms
// out      | output    | out_valid_o / out_stall_i | display_rotation, orientation,
//          |           |                          | rotation_changed
// cfg      | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// one sample per cycle sustained while the result is not stalled; a beat lands in
// the input register, and the whole tilt/yaw/commit update runs combinationally
// from it into the result register and the state registers.
// the state feedback (yaw multiply-add and commit decision) sets the cycle.
// reset returns the configuration and state registers to their defaults and empties both stages.
// a stalled result holds, the input register fills behind it, then in_stall_o
// rises until the result beat is taken.
module tilt_orientation_detector #(
  parameter int unsigned SAMPLE_BITS = tod_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tod_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tod_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] accel_x_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_y_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_z_i,
  input  logic signed [SAMPLE_BITS-1:0] gyro_z_i,
  input  logic [15:0]                   elapsed_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    display_rotation_o,
  output logic [2:0]                    orientation_o,
  output logic                          rotation_changed_o
);

  tod_pkg::cfg_t    cfg_q;
  tod_pkg::state_t  state_q, state_d;
  tod_pkg::result_t res_d, res_q;

  logic                          in_valid_q, out_valid_q;
  logic signed [SAMPLE_BITS-1:0] ax_q, ay_q, az_q, gz_q;
  logic [15:0]                   dt_q;
  logic                          in_accept, advance;

  // handshake
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tod_pkg::CfgRst;
    end else if (cfg_we_i) begin
      unique case (tod_pkg::cfg_idx_e'(cfg_index_i))
        tod_pkg::CFG_TILT_THRESHOLD: cfg_q.tilt_threshold      <= cfg_data_i[14:0];
        tod_pkg::CFG_AXIS_MARGIN:    cfg_q.axis_margin         <= cfg_data_i[14:0];
        tod_pkg::CFG_FLAT_THRESHOLD: cfg_q.flat_threshold      <= cfg_data_i[14:0];
        tod_pkg::CFG_GYRO_NOISE:     cfg_q.gyro_noise          <= cfg_data_i[14:0];
        tod_pkg::CFG_FLIP_YAW:       cfg_q.flip_yaw_threshold  <= cfg_data_i[23:0];
        tod_pkg::CFG_STABLE_SAMPLES: cfg_q.stable_samples      <= cfg_data_i[3:0];
        tod_pkg::CFG_MIN_GAP_MS:     cfg_q.min_rotation_gap_ms <= cfg_data_i[15:0];
        tod_pkg::CFG_ROT_OFFSET:     cfg_q.rotation_offset     <= cfg_data_i[1:0];
        default:                     cfg_q <= cfg_q;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gz_q <= gyro_z_i;
      dt_q <= elapsed_ms_i;
    end
  end

  // combinational detector update
  tod_step #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_step (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .accel_x_i   (ax_q),
    .accel_y_i   (ay_q),
    .accel_z_i   (az_q),
    .gyro_z_i    (gz_q),
    .elapsed_ms_i(dt_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  // detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tod_pkg::StateRst;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign display_rotation_o = res_q.display_rotation;
  assign orientation_o      = res_q.orientation;
  assign rotation_changed_o = res_q.rotation_changed;

`ifndef NO_ASSERTIONS
  // a commit always comes from a known or flipped orientation
  a_commit_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rotation_changed_o |-> orientation_o != tod_pkg::ORIENT_UNKNOWN)
    else $error("commit reported with unknown orientation");

  // committed rotation moves only on a committing update
  a_commit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(state_q.committed_rotation) |-> $past(advance && res_d.rotation_changed))
    else $error("committed rotation changed without a commit");

  // input stalls only while the input register is occupied and blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  // a committing result shows the rotation it committed
  a_commit_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.rotation_changed |=> display_rotation_o == state_q.committed_rotation)
    else $error("result does not show committed rotation");
`endif

endmodule

@@ tb/tilt_orientation_detector_tb.sv @@
module tilt_orientation_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one imu sample as driven on the input channel
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [15:0] gz;
    logic [15:0] dt;
  } imu_sample_t;

  // one result beat as it should leave the block
  typedef struct packed {
    logic [1:0] display_rotation;
    logic [2:0] orientation;
    logic       rotation_changed;
  } rotation_beat_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         cfg_we_i     = 1'b0;
  logic [tod_pkg::CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [tod_pkg::CfgDataW-1:0] cfg_data_i   = '0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_stall_o;
  logic signed [15:0]           accel_x_i    = '0;
  logic signed [15:0]           accel_y_i    = '0;
  logic signed [15:0]           accel_z_i    = '0;
  logic signed [15:0]           gyro_z_i     = '0;
  logic [15:0]                  elapsed_ms_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i  = 1'b0;
  logic [1:0]                   display_rotation_o;
  logic [2:0]                   orientation_o;
  logic                         rotation_changed_o;

  // shadow copy of the configuration registers
  logic [14:0] tilt_thr   = 15'd1556;
  logic [14:0] axis_mg    = 15'd123;
  logic [14:0] flat_thr   = 15'd3359;
  logic [14:0] noise_thr  = 15'd64;
  logic [23:0] flip_thr   = 24'd1120000;
  logic [3:0]  stable_req = 4'd3;
  logic [15:0] gap_ms     = 16'd850;
  logic [1:0]  rot_offset = 2'd1;

  // tracked detector state
  logic [1:0]  commit_rot = 2'd1;
  logic [1:0]  cand_rot   = 2'd1;
  logic [3:0]  stable_cnt = 4'd0;
  int          yaw_acc    = 0;
  logic [15:0] ms_since   = 16'd0;

  imu_sample_t    sample_q[$];
  rotation_beat_t rotation_q[$];
  imu_sample_t    cur_sample;
  int unsigned    burst_left = 0;
  int unsigned    gap_left   = 0;
  int unsigned    stall_mode = 0;
  int unsigned    stall_left = 0;
  int unsigned    mismatch_cnt = 0;

  always #2 clk_i = ~clk_i;

  tilt_orientation_detector u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .accel_x_i,
    .accel_y_i,
    .accel_z_i,
    .gyro_z_i,
    .elapsed_ms_i,
    .out_valid_o,
    .out_stall_i,
    .display_rotation_o,
    .orientation_o,
    .rotation_changed_o
  );

  // physical rotation to display rotation
  function automatic logic [1:0] to_display(input logic [1:0] phys);
    return phys + rot_offset;
  endfunction

  // step the tracked state on one accepted sample and queue its result
  task automatic track_sample(input imu_sample_t s);
    longint           ax, ay, az, gz, absx, absy, yaw_sum, yaw_mag;
    int unsigned      ms_sum;
    logic [1:0]       target, phys_back;
    tod_pkg::orient_e orient;
    logic             chg;
    rotation_beat_t   beat;
    ax = longint'($signed(s.ax));
    ay = longint'($signed(s.ay));
    az = longint'($signed(s.az));
    gz = longint'($signed(s.gz));
    absx = (ax < 0) ? -ax : ax;
    absy = (ay < 0) ? -ay : ay;
    orient = tod_pkg::ORIENT_UNKNOWN;
    target = commit_rot;
    chg = 1'b0;

    // elapsed time, saturating
    ms_sum = ms_since + s.dt;
    if (ms_sum > 65535) ms_sum = 65535;
    ms_since = ms_sum[15:0];

    // dominant tilt axis
    if (absx < longint'(tilt_thr) && absy < longint'(tilt_thr)) begin
      orient = tod_pkg::ORIENT_UNKNOWN;
    end else if (absx >= absy + longint'(axis_mg)) begin
      if (ax >= 0) begin
        orient = tod_pkg::ORIENT_PORTRAIT;
        target = to_display(2'd0);
      end else begin
        orient = tod_pkg::ORIENT_PORTRAIT_FLIP;
        target = to_display(2'd2);
      end
    end else if (absy >= absx + longint'(axis_mg)) begin
      if (ay >= 0) begin
        orient = tod_pkg::ORIENT_LANDSCAPE;
        target = to_display(2'd1);
      end else begin
        orient = tod_pkg::ORIENT_LANDSCAPE_FLIP;
        target = to_display(2'd3);
      end
    end

    // yaw tracking while flat with no clear tilt
    if (orient == tod_pkg::ORIENT_UNKNOWN) begin
      if (((az < 0) ? -az : az) < longint'(flat_thr)) begin
        yaw_acc = 0;
      end else begin
        if (((gz < 0) ? -gz : gz) > longint'(noise_thr)) begin
          yaw_sum = longint'(yaw_acc) + gz * longint'(s.dt);
          if (yaw_sum > 64'sd2147483647) yaw_sum = 64'sd2147483647;
          if (yaw_sum < -64'sd2147483648) yaw_sum = -64'sd2147483648;
          yaw_acc = int'(yaw_sum);
        end else begin
          yaw_acc = int'((longint'(yaw_acc) * 963) / 1024);
        end
        yaw_mag = (yaw_acc < 0) ? -longint'(yaw_acc) : longint'(yaw_acc);
        // yaw past the flip angle forces the opposite rotation
        if (yaw_mag >= longint'(flip_thr)) begin
          target = commit_rot + 2'd2;
          phys_back = target - rot_offset;
          orient = tod_pkg::orient_e'({1'b0, phys_back} + 3'd1);
          yaw_acc = 0;
          cand_rot = target;
          stable_cnt = stable_req;
        end
      end
    end

    // debounce and commit
    if (orient == tod_pkg::ORIENT_UNKNOWN) begin
      stable_cnt = 4'd0;
    end else begin
      yaw_acc = 0;
      if (target != cand_rot) begin
        cand_rot = target;
        stable_cnt = 4'd1;
      end else if (stable_cnt < stable_req) begin
        stable_cnt = stable_cnt + 4'd1;
      end else if (target != commit_rot && ms_since >= gap_ms) begin
        commit_rot = target;
        ms_since = 16'd0;
        chg = 1'b1;
      end
    end

    beat.display_rotation = commit_rot;
    beat.orientation = orient;
    beat.rotation_changed = chg;
    rotation_q.push_back(beat);
  endtask

  // sender: bursts of beats with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) track_sample(cur_sample);
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (sample_q.size() != 0) begin
        cur_sample = sample_q.pop_front();
        accel_x_i <= cur_sample.ax;
        accel_y_i <= cur_sample.ay;
        accel_z_i <= cur_sample.az;
        gyro_z_i <= cur_sample.gz;
        elapsed_ms_i <= cur_sample.dt;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: check each result beat, stall on its own pattern
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (rotation_q.size() == 0) begin
        $error("result beat with nothing expected");
        mismatch_cnt++;
      end else begin
        if (display_rotation_o !== rotation_q[0].display_rotation) begin
          $error("display_rotation: expected %0d, got %0d",
                 rotation_q[0].display_rotation, display_rotation_o);
          mismatch_cnt++;
        end
        if (orientation_o !== rotation_q[0].orientation) begin
          $error("orientation: expected %0d, got %0d",
                 rotation_q[0].orientation, orientation_o);
          mismatch_cnt++;
        end
        if (rotation_changed_o !== rotation_q[0].rotation_changed) begin
          $error("rotation_changed: expected %0d, got %0d",
                 rotation_q[0].rotation_changed, rotation_changed_o);
          mismatch_cnt++;
        end
        void'(rotation_q.pop_front());
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) != 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // write one register and keep the shadow copy in step
  task automatic write_reg(input tod_pkg::cfg_idx_e idx, input logic [23:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      tod_pkg::CFG_TILT_THRESHOLD: tilt_thr = data[14:0];
      tod_pkg::CFG_AXIS_MARGIN:    axis_mg = data[14:0];
      tod_pkg::CFG_FLAT_THRESHOLD: flat_thr = data[14:0];
      tod_pkg::CFG_GYRO_NOISE:     noise_thr = data[14:0];
      tod_pkg::CFG_FLIP_YAW:       flip_thr = data;
      tod_pkg::CFG_STABLE_SAMPLES: stable_req = data[3:0];
      tod_pkg::CFG_MIN_GAP_MS:     gap_ms = data[15:0];
      default:                     rot_offset = data[1:0];
    endcase
  endtask

  // write all eight registers, optionally with junk above each field but the flip threshold
  task automatic apply_setting(input logic [14:0] tilt, input logic [14:0] margin,
                               input logic [14:0] flat, input logic [14:0] noise,
                               input logic [23:0] flip, input logic [3:0] stable,
                               input logic [15:0] gap, input logic [1:0] offset,
                               input bit junk);
    logic [31:0] r;
    r = junk ? $urandom : 32'd0;
    write_reg(tod_pkg::CFG_TILT_THRESHOLD, {r[8:0], tilt});
    write_reg(tod_pkg::CFG_AXIS_MARGIN, {r[9:1], margin});
    write_reg(tod_pkg::CFG_FLAT_THRESHOLD, {r[10:2], flat});
    write_reg(tod_pkg::CFG_GYRO_NOISE, {r[11:3], noise});
    write_reg(tod_pkg::CFG_FLIP_YAW, flip);
    write_reg(tod_pkg::CFG_STABLE_SAMPLES, {r[19:0], stable});
    write_reg(tod_pkg::CFG_MIN_GAP_MS, {r[27:20], gap});
    write_reg(tod_pkg::CFG_ROT_OFFSET, {r[31:10], offset});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid_i || rotation_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic add_sample(input logic [15:0] ax, input logic [15:0] ay,
                            input logic [15:0] az, input logic [15:0] gz,
                            input logic [15:0] dt);
    imu_sample_t s;
    s = '{ax: ax, ay: ay, az: az, gz: gz, dt: dt};
    sample_q.push_back(s);
  endtask

  function automatic logic [15:0] with_sign(input int unsigned mg);
    logic [15:0] r;
    r = mg[15:0];
    if ($urandom_range(0, 1) != 0) r = -r;
    return r;
  endfunction

  // random value with magnitude strictly below lim
  function automatic logic [15:0] below(input int unsigned lim);
    int unsigned mg;
    if (lim == 0) return 16'd0;
    mg = $urandom_range(0, (lim > 32768) ? 32767 : lim - 1);
    return with_sign(mg);
  endfunction

  function automatic logic [15:0] pick_dt();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 400));
  endfunction

  // mostly steady tilt runs and flat spins, some edge values and noise
  task automatic queue_motion(input int unsigned n_items);
    int unsigned kind, run, k, m, o;
    logic [15:0] dom, oth;
    bit on_x, neg;
    k = 0;
    while (k < n_items) begin
      kind = $urandom_range(0, 9);
      run = $urandom_range(1, 18);
      on_x = 1'($urandom_range(0, 1));
      neg = 1'($urandom_range(0, 1));
      for (int unsigned i = 0; i < run && k < n_items; i++) begin
        if (kind <= 4) begin
          // steady tilt on one axis and sign
          m = $urandom_range(tilt_thr, 32767);
          dom = neg ? -m[15:0] : m[15:0];
          if (neg && $urandom_range(0, 7) == 0) dom = 16'h8000;
          oth = (m > axis_mg) ? below(m - axis_mg) : 16'd0;
          if (on_x) add_sample(dom, oth, 16'($urandom), 16'($urandom), pick_dt());
          else add_sample(oth, dom, 16'($urandom), 16'($urandom), pick_dt());
        end else if (kind <= 6) begin
          // lying flat and spinning, sometimes below the noise floor
          dom = with_sign($urandom_range(flat_thr, 32767));
          if ($urandom_range(0, 3) != 0) oth = with_sign($urandom_range(0, 32768));
          else oth = below(noise_thr + 1);
          add_sample(below(tilt_thr), below(tilt_thr), dom, oth,
                     ($urandom_range(0, 7) == 0) ? pick_dt()
                                                 : 16'($urandom_range(1, 200)));
        end else if (kind == 7) begin
          // edges of the tilt threshold and the axis margin
          m = (tilt_thr == 0) ? 0 : tilt_thr - $urandom_range(0, 1);
          o = (m >= axis_mg) ? m - axis_mg + $urandom_range(0, 1) : $urandom_range(0, 1);
          if (on_x) begin
            add_sample(with_sign(m), with_sign(o), 16'($urandom), 16'($urandom), pick_dt());
          end else begin
            add_sample(with_sign(o), with_sign(m), 16'($urandom), 16'($urandom), pick_dt());
          end
        end else begin
          add_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        end
        k++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed samples at reset settings
    add_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    repeat (4) add_sample(16'd32767, 16'd0, 16'd4096, 16'd0, 16'd300);
    add_sample(16'h8000, 16'd0, 16'd0, 16'd0, 16'd300);
    add_sample(16'd0, 16'h8000, 16'd0, 16'd0, 16'd300);
    add_sample(16'd0, 16'd32767, 16'd0, 16'd0, 16'd300);
    add_sample(16'd20000, -16'sd20000, 16'd0, 16'd0, 16'd10);
    add_sample(16'd1555, 16'd0, 16'd0, 16'd0, 16'd10);
    add_sample(16'd1556, 16'd1433, 16'd0, 16'd0, 16'd10);
    add_sample(16'd1556, 16'd1434, 16'd0, 16'd0, 16'd10);
    add_sample(16'd0, 16'd0, 16'd4096, 16'd32767, 16'd100);
    add_sample(16'd0, 16'd0, -16'sd4096, 16'd500, 16'd100);
    add_sample(16'd0, 16'd0, 16'd4096, 16'd64, 16'd10);
    add_sample(16'd0, 16'd0, 16'd4096, -16'sd65, 16'd10);
    add_sample(16'd0, 16'd0, 16'd3358, 16'd1000, 16'd10);
    add_sample(16'd0, 16'd0, 16'h8000, 16'h8000, 16'hFFFF);
    add_sample(16'd0, 16'd0, 16'd32767, 16'd0, 16'hFFFF);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_sample(16'd32767, 16'h8000, 16'd0, 16'd0, 16'd1);
    wait_drained();

    apply_setting(15'd1200, 15'd200, 15'd3000, 15'd40, 24'd400000, 4'd2, 16'd300,
                  2'd2, 1'b0);
    queue_motion(500);
    wait_drained();

    // all minimum, debounce count of zero
    apply_setting(15'd0, 15'd0, 15'd0, 15'd0, 24'd0, 4'd0, 16'd0, 2'd0, 1'b0);
    queue_motion(300);
    wait_drained();

    // all maximum
    apply_setting(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 24'hFFFFFF, 4'd15, 16'hFFFF,
                  2'd3, 1'b0);
    queue_motion(300);
    wait_drained();

    apply_setting(15'd1556, 15'd123, 15'd3359, 15'd64, 24'd200000, 4'd0, 16'd100,
                  2'd3, 1'b0);
    queue_motion(300);
    wait_drained();

    // random settings with junk above each field but the flip threshold
    repeat (3) begin
      apply_setting(15'($urandom_range(0, 6000)), 15'($urandom_range(0, 1000)),
                    15'($urandom_range(0, 8000)), 15'($urandom_range(0, 2000)),
                    24'(($urandom_range(0, 3) == 0) ? $urandom
                                                    : $urandom_range(0, 3000000)),
                    4'($urandom_range(1, 15)), 16'($urandom_range(0, 2000)),
                    2'($urandom_range(0, 3)), 1'b1);
      queue_motion(200);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tod_pkg.sv
hw/rtl/tod_step.sv
hw/rtl/tilt_orientation_detector.sv
tb/tilt_orientation_detector_tb.sv
